// ===== rtl/ik_pkg.sv =====
// shared types and constants of the isaac key stream generator
`default_nettype none
package ik_pkg;

    localparam int STORE_AW = 8;
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    localparam logic [1:0] REG_SEED_0 = 2'd0;
    localparam logic [1:0] REG_SEED_1 = 2'd1;
    localparam logic [1:0] REG_SEED_2 = 2'd2;
    localparam logic [1:0] REG_SEED_3 = 2'd3;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] words_t;
    typedef logic [3:0][31:0] seeds_t;

    // request from the control to the engine
    typedef struct packed {
        logic seed;
        logic new_block;
    } eng_cmd_t;

    // control of the eight-word scramble bank
    typedef struct packed {
        logic       init;
        logic       add_en;
        logic [2:0] add_idx;
        word_t      add_val;
        logic       step_en;
        logic [2:0] step;
    } scr_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/ik_scramble.sv =====
// eight-word seeding bank, one scramble step per cycle
`default_nettype none
module ik_scramble
    import ik_pkg::*;
(
    input  wire logic     aclk,
    input  wire scr_cmd_t cmd,
    output words_t        w
);

    word_t w_reg [8];
    word_t w_next [8];

    // shift of one scramble step
    function automatic word_t step_shift(input word_t v, input logic [2:0] s);
        word_t r;
        case (s)
            3'd0:    r = v << 11;
            3'd1:    r = v >> 2;
            3'd2:    r = v << 8;
            3'd3:    r = v >> 16;
            3'd4:    r = v << 10;
            3'd5:    r = v >> 4;
            3'd6:    r = v << 8;
            default: r = v >> 9;
        endcase
        return r;
    endfunction

    // next word values
    always_comb begin
        logic [2:0] ia, ib, ic, id;
        word_t      wa;
        ia = cmd.step;
        ib = cmd.step + 3'd1;
        ic = cmd.step + 3'd2;
        id = cmd.step + 3'd3;
        wa = w_reg[ia] ^ step_shift(w_reg[ib], cmd.step);
        for (int k = 0; k < 8; k++) begin
            w_next[k] = w_reg[k];
        end
        if (cmd.init) begin
            for (int k = 0; k < 8; k++) begin
                w_next[k] = GOLDEN;
            end
        end else if (cmd.add_en) begin
            w_next[cmd.add_idx] = w_reg[cmd.add_idx] + cmd.add_val;
        end else if (cmd.step_en) begin
            w_next[ia] = wa;
            w_next[id] = w_reg[id] + wa;
            w_next[ib] = w_reg[ib] + w_reg[ic];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 8; k++) begin
            w_reg[k] <= w_next[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w[k] = w_reg[k];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ik_engine.sv =====
// seeding and block generation over the mix and result memories
`default_nettype none
module ik_engine
    import ik_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire eng_cmd_t            cmd,
    input  wire seeds_t              seed_words,
    output logic                     done,
    input  wire logic                key_rd_en,
    input  wire logic [STORE_AW-1:0] key_rd_addr,
    output word_t                    key_rd_data
);

    typedef enum logic [3:0] {
        E_IDLE, E_GOLD, E_LOAD, E_SCR, E_WRITE, E_NB,
        E_R0, E_R1, E_R2, E_R3, E_R4, E_DONE
    } eng_state_t;

    eng_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] k_reg, k_next;
    logic [4:0] grp_reg, grp_next;
    logic       pass_reg, pass_next;
    logic [STORE_AW-1:0] i_reg, i_next;
    word_t acc_reg, acc_next;
    word_t last_reg, last_next;
    word_t bcnt_reg, bcnt_next;
    word_t x_reg, x_next;
    word_t y_reg, y_next;
    logic  fwd_reg, fwd_next;

    word_t mix_mem [2**STORE_AW];
    word_t res_mem [2**STORE_AW];
    word_t mix_rdata;
    logic                mix_re, mix_we, res_we;
    logic [STORE_AW-1:0] mix_raddr, mix_waddr;
    word_t               mix_wdata, res_wdata;

    scr_cmd_t scmd;
    words_t   w;

    ik_scramble u_scramble (
        .aclk (aclk),
        .cmd  (scmd),
        .w    (w)
    );

    // memories with registered read data
    always_ff @(posedge aclk) begin
        if (mix_we) begin
            mix_mem[mix_waddr] <= mix_wdata;
        end
        if (mix_re) begin
            mix_rdata <= mix_mem[mix_raddr];
        end
        if (res_we) begin
            res_mem[i_reg] <= res_wdata;
        end
        if (key_rd_en) begin
            key_rd_data <= res_mem[key_rd_addr];
        end
    end

    // accumulator shift by word position
    function automatic word_t acc_mix(input word_t a, input logic [1:0] p);
        word_t r;
        case (p)
            2'd0:    r = a ^ (a << 13);
            2'd1:    r = a ^ (a >> 6);
            2'd2:    r = a ^ (a << 2);
            default: r = a ^ (a >> 16);
        endcase
        return r;
    endfunction

    // sequencer
    always_comb begin
        logic [2:0] km1;
        word_t      y, lr;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        grp_next   = grp_reg;
        pass_next  = pass_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        last_next  = last_reg;
        bcnt_next  = bcnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        fwd_next   = fwd_reg;
        scmd       = '0;
        mix_re     = 1'b0;
        mix_raddr  = i_reg;
        mix_we     = 1'b0;
        mix_waddr  = i_reg;
        mix_wdata  = w[0];
        res_we     = 1'b0;
        res_wdata  = last_reg;
        done       = 1'b0;
        km1        = k_reg[2:0] - 3'd1;
        y          = mix_rdata + acc_reg + last_reg;
        lr         = (fwd_reg ? y_reg : mix_rdata) + x_reg;
        case (state_reg)
            E_IDLE: begin
                if (cmd.seed) begin
                    scmd.init  = 1'b1;
                    acc_next   = '0;
                    last_next  = '0;
                    bcnt_next  = '0;
                    cnt_next   = '0;
                    state_next = E_GOLD;
                end else if (cmd.new_block) begin
                    state_next = E_NB;
                end
            end
            // four scrambles of the golden words
            E_GOLD: begin
                scmd.step_en = 1'b1;
                scmd.step    = cnt_reg[2:0];
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    k_next     = '0;
                    grp_next   = '0;
                    pass_next  = 1'b0;
                    state_next = E_LOAD;
                end
            end
            // add eight source words into the bank
            E_LOAD: begin
                if (pass_reg && k_reg != 4'd8) begin
                    mix_re    = 1'b1;
                    mix_raddr = {grp_reg, k_reg[2:0]};
                end
                if (k_reg != 4'd0) begin
                    scmd.add_en  = 1'b1;
                    scmd.add_idx = km1;
                    if (pass_reg) begin
                        scmd.add_val = mix_rdata;
                    end else if (grp_reg == 5'd0 && km1[2] == 1'b0) begin
                        scmd.add_val = seed_words[km1[1:0]];
                    end else begin
                        scmd.add_val = '0;
                    end
                end
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd8) begin
                    cnt_next   = '0;
                    state_next = E_SCR;
                end
            end
            E_SCR: begin
                scmd.step_en = 1'b1;
                scmd.step    = cnt_reg[2:0];
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg[2:0] == 3'd7) begin
                    k_next     = '0;
                    state_next = E_WRITE;
                end
            end
            // store the bank into the mix memory
            E_WRITE: begin
                mix_we    = 1'b1;
                mix_waddr = {grp_reg, k_reg[2:0]};
                mix_wdata = w[k_reg[2:0]];
                k_next    = k_reg + 4'd1;
                if (k_reg[2:0] == 3'd7) begin
                    k_next   = '0;
                    grp_next = grp_reg + 5'd1;
                    if (grp_reg == 5'd31) begin
                        if (pass_reg) begin
                            state_next = E_NB;
                        end else begin
                            pass_next  = 1'b1;
                            state_next = E_LOAD;
                        end
                    end else begin
                        state_next = E_LOAD;
                    end
                end
            end
            E_NB: begin
                bcnt_next  = bcnt_reg + 32'd1;
                last_next  = last_reg + bcnt_reg + 32'd1;
                i_next     = '0;
                state_next = E_R0;
            end
            // one result word in five steps
            E_R0: begin
                mix_re     = 1'b1;
                mix_raddr  = i_reg;
                state_next = E_R1;
            end
            E_R1: begin
                mix_re     = 1'b1;
                mix_raddr  = i_reg + 8'd128;
                x_next     = mix_rdata;
                state_next = E_R2;
            end
            E_R2: begin
                mix_re     = 1'b1;
                mix_raddr  = x_reg[9:2];
                acc_next   = acc_mix(acc_reg, i_reg[1:0]) + mix_rdata;
                state_next = E_R3;
            end
            E_R3: begin
                mix_we     = 1'b1;
                mix_waddr  = i_reg;
                mix_wdata  = y;
                mix_re     = 1'b1;
                mix_raddr  = y[17:10];
                y_next     = y;
                fwd_next   = (y[17:10] == i_reg);
                state_next = E_R4;
            end
            E_R4: begin
                last_next = lr;
                res_we    = 1'b1;
                res_wdata = lr;
                i_next    = i_reg + 8'd1;
                if (i_reg == 8'd255) begin
                    state_next = E_DONE;
                end else begin
                    state_next = E_R0;
                end
            end
            E_DONE: begin
                done       = 1'b1;
                state_next = E_IDLE;
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            grp_reg   <= '0;
            pass_reg  <= 1'b0;
            i_reg     <= '0;
            acc_reg   <= '0;
            last_reg  <= '0;
            bcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            grp_reg   <= grp_next;
            pass_reg  <= pass_next;
            i_reg     <= i_next;
            acc_reg   <= acc_next;
            last_reg  <= last_next;
            bcnt_reg  <= bcnt_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        fwd_reg <= fwd_next;
    end

endmodule
`default_nettype wire

// ===== rtl/isaac_key_stream.sv =====
// top level of the isaac key stream generator
`default_nettype none
// ISAAC 32-bit key stream. Each transfer on the s_ side requests one key,
// delivered as one transfer on the m_ side. A key served from the stored
// block passes through the result memory read and the output register.
// Every 256 keys a new block is generated first, paced by the five mix
// memory accesses per word. A seeding (restart set, or the first request
// after reset) runs 32 scramble steps, then two passes of 32 groups of
// load, scramble and write, then one block generation. Seed registers take
// effect at the next seeding.
module isaac_key_stream
    import ik_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] key
);

    typedef enum logic [1:0] {T_IDLE, T_RUN, T_READ, T_OUT} top_state_t;

    top_state_t state_reg;
    seeds_t     seed_reg;
    logic [STORE_AW-1:0] ridx_reg;
    logic       seeded_reg;
    logic       m_tvalid_reg;
    word_t      m_tdata_reg;
    eng_cmd_t   cmd;
    logic       eng_done;
    word_t      key_rd_data;
    logic       accept;

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // engine request on an accepted transfer
    always_comb begin
        cmd.seed      = accept && (s_tdata[0] || !seeded_reg);
        cmd.new_block = accept && !cmd.seed && (ridx_reg == '0);
    end

    ik_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .seed_words  (seed_reg),
        .done        (eng_done),
        .key_rd_en   (state_reg == T_READ),
        .key_rd_addr (ridx_reg),
        .key_rd_data (key_rd_data)
    );

    // seed registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SEED_0: seed_reg[0] <= cfg_wdata;
                REG_SEED_1: seed_reg[1] <= cfg_wdata;
                REG_SEED_2: seed_reg[2] <= cfg_wdata;
                REG_SEED_3: seed_reg[3] <= cfg_wdata;
                default:    seed_reg <= seed_reg;
            endcase
        end
    end

    // request control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            ridx_reg     <= '0;
            seeded_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == T_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        if (cmd.seed || cmd.new_block) begin
                            seeded_reg <= 1'b1;
                            ridx_reg   <= '1;
                            state_reg  <= T_RUN;
                        end else begin
                            ridx_reg  <= ridx_reg - 1'b1;
                            state_reg <= T_READ;
                        end
                    end
                end
                T_RUN: begin
                    if (eng_done) begin
                        state_reg <= T_READ;
                    end
                end
                T_READ: state_reg <= T_OUT;
                T_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == T_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= key_rd_data;
        end
    end

endmodule
`default_nettype wire

// ===== sim/isaac_key_checker.sv =====
// key stream predictor and result checker for the isaac key stream generator
`timescale 1ns / 100ps
`default_nettype none
module isaac_key_checker
    import ik_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               fail_count,
    output int               keys_pending
);

    word_t seed_reg [4];
    word_t mix_mem [256];
    word_t res_mem [256];
    word_t acc;
    word_t last_key;
    word_t blk_cnt;
    int    rd_idx;
    bit    is_seeded;
    word_t key_queue [$];

    // one eight-word scramble round
    function automatic words_t scramble_words(input words_t w);
        w[0] ^= w[1] << 11; w[3] += w[0]; w[1] += w[2];
        w[1] ^= w[2] >> 2;  w[4] += w[1]; w[2] += w[3];
        w[2] ^= w[3] << 8;  w[5] += w[2]; w[3] += w[4];
        w[3] ^= w[4] >> 16; w[6] += w[3]; w[4] += w[5];
        w[4] ^= w[5] << 10; w[7] += w[4]; w[5] += w[6];
        w[5] ^= w[6] >> 4;  w[0] += w[5]; w[6] += w[7];
        w[6] ^= w[7] << 8;  w[1] += w[6]; w[7] += w[0];
        w[7] ^= w[0] >> 9;  w[2] += w[7]; w[0] += w[1];
        return w;
    endfunction

    // generate one block of 256 keys
    task automatic gen_block();
        word_t x;
        word_t y;
        blk_cnt += 1;
        last_key += blk_cnt;
        for (int i = 0; i < 256; i++) begin
            x = mix_mem[i];
            case (i & 3)
                0: acc ^= acc << 13;
                1: acc ^= acc >> 6;
                2: acc ^= acc << 2;
                default: acc ^= acc >> 16;
            endcase
            acc += mix_mem[(i + 128) & 255];
            y = mix_mem[(x >> 2) & 255] + acc + last_key;
            mix_mem[i] = y;
            last_key = mix_mem[(y >> 10) & 255] + x;
            res_mem[i] = last_key;
        end
    endtask

    // fresh seeding from the seed registers
    task automatic seed_state();
        words_t w;
        word_t  src [256];
        for (int i = 0; i < 256; i++) begin
            src[i] = (i < 4) ? seed_reg[i] : '0;
            mix_mem[i] = '0;
        end
        acc = '0;
        last_key = '0;
        blk_cnt = '0;
        for (int k = 0; k < 8; k++) w[k] = GOLDEN;
        for (int k = 0; k < 4; k++) w = scramble_words(w);
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < 256; i += 8) begin
                for (int k = 0; k < 8; k++)
                    w[k] += (p == 0) ? src[i + k] : mix_mem[i + k];
                w = scramble_words(w);
                for (int k = 0; k < 8; k++) mix_mem[i + k] = w[k];
            end
        end
        gen_block();
        rd_idx = 256;
        is_seeded = 1'b1;
    endtask

    assign keys_pending = key_queue.size();

    // watch config, requests and keys
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) seed_reg[i] = '0;
            acc = '0;
            last_key = '0;
            blk_cnt = '0;
            rd_idx = 0;
            is_seeded = 1'b0;
            key_queue.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) seed_reg[cfg_addr] = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (s_tdata[0] || !is_seeded) seed_state();
                if (rd_idx == 0) begin
                    gen_block();
                    rd_idx = 255;
                end else begin
                    rd_idx -= 1;
                end
                key_queue.push_back(res_mem[rd_idx]);
            end
            if (m_tvalid && m_tready) begin
                if (key_queue.size() == 0) begin
                    $error("key transfer with none expected: actual %h", m_tdata);
                    fail_count++;
                end else begin
                    if (m_tdata !== key_queue[0]) begin
                        $error("key mismatch: expected %h actual %h",
                               key_queue[0], m_tdata);
                        fail_count++;
                    end
                    void'(key_queue.pop_front());
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// stimulus and verdict for the isaac key stream generator
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import ik_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = REG_SEED_0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] key
    int          fail_count;
    int          keys_pending;
    bit          no_idle = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    isaac_key_stream uut (.*);

    isaac_key_checker chk (.*);

    // receiver with random stalls
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 24);
    end

    // wait for all keys, then a short drain
    task automatic drain_keys();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (keys_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_seeds(input word_t w0, input word_t w1,
                               input word_t w2, input word_t w3);
        word_t vals [4];
        vals = '{w0, w1, w2, w3};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= i[1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one key request transfer, optional gap first
    task automatic request_key(input bit restart, input bit may_idle);
        if (may_idle && !no_idle && ($urandom_range(99) < 24)) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'($urandom_range(127)), restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: first request seeds with zero registers
        request_key(1'b0, 1'b0);
        request_key(1'b0, 1'b0);
        request_key(1'b1, 1'b0);
        drain_keys();
        write_seeds('1, '1, '1, '1);
        request_key(1'b0, 1'b0);
        request_key(1'b1, 1'b0);
        for (int i = 0; i < 6; i++) request_key(1'b0, 1'b1);
        drain_keys();
        write_seeds(32'h8000_0000, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa);
        request_key(1'b1, 1'b0);
        request_key(1'b1, 1'b0);
        drain_keys();
        // random phases; each run starts with a restart and stays within one block
        for (int ph = 0; ph < 4; ph++) begin
            write_seeds($urandom, $urandom, $urandom, $urandom);
            no_idle = (ph == 2);
            request_key(1'b1, 1'b1);
            for (int i = 0; i < 235; i++)
                request_key($urandom_range(99) == 0, 1'b1);
            drain_keys();
        end
        no_idle = 1'b0;
        drain_keys();
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/ik_pkg.sv
rtl/ik_scramble.sv
rtl/ik_engine.sv
rtl/isaac_key_stream.sv
sim/isaac_key_checker.sv
sim/testbench.sv
